[rtl/mm4_pkg.sv]
// shared constants and types for the 4x4 fixed point matrix multiplier
package mm4_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int DIM      = 4;
  localparam int ELEMS    = DIM * DIM;
  localparam int ADDR_W   = $clog2(ELEMS);
  localparam int DIM_W    = $clog2(DIM);
  localparam int STEPS    = 2 * DIM;
  localparam int STEP_W   = $clog2(STEPS);

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic mul_en;
    logic hi_half;
  } mac_ctrl_t;

endpackage

[rtl/mm4_store.sv]
// 16-entry matrix element store, one write port and one registered read port
module mm4_store #(
  parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [mm4_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [DATA_WIDTH-1:0]       wr_data,
  input  logic [mm4_pkg::ADDR_W-1:0]  rd_addr,
  output logic [DATA_WIDTH-1:0]       rd_data
);

  logic [DATA_WIDTH-1:0] mem [mm4_pkg::ELEMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mm4_pkg::ELEMS; i++) begin
        mem[i] <= '0;
      end
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/mm4_mac.sv]
// shared multiplier, wide accumulator and truncate/saturate stage
module mm4_mac #(
  parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mm4_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mm4_pkg::mac_ctrl_t     ctrl,
  input  logic [DATA_WIDTH-1:0]  left_op,
  input  logic [DATA_WIDTH-1:0]  right_op,
  output logic [DATA_WIDTH-1:0]  result,
  output logic                   sat
);

  localparam int H     = (DATA_WIDTH + 1) / 2;
  localparam int PW    = DATA_WIDTH + H + 1;
  localparam int ACC_W = 2 * DATA_WIDTH + 2;
  localparam int UP_W  = ACC_W - DATA_WIDTH + 1;

  localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [DATA_WIDTH-1:0] right_sh;
  logic [H:0]                   b_part;
  logic signed [PW-1:0]         a_ext;
  logic signed [PW-1:0]         b_ext;
  logic signed [PW-1:0]         prod;
  logic                         mul_en_d;
  logic                         hi_d;
  logic                         prod_vld;
  logic                         prod_hi;
  logic signed [ACC_W-1:0]      prod_wide;
  logic signed [ACC_W-1:0]      addend;
  logic signed [ACC_W-1:0]      acc;
  logic signed [ACC_W-1:0]      acc_sh;
  logic [UP_W-1:0]              upper;
  logic                         fits;

  // right operand split into an unsigned low half and a signed high half
  assign right_sh = $signed(right_op) >>> H;
  assign b_part   = hi_d ? right_sh[H:0] : {1'b0, right_op[H-1:0]};
  assign a_ext    = {{(PW-DATA_WIDTH){left_op[DATA_WIDTH-1]}}, left_op};
  assign b_ext    = {{(PW-H-1){b_part[H]}}, b_part};

  always_ff @(posedge clk) begin
    prod <= a_ext * b_ext;
    if (rst) begin
      mul_en_d <= 1'b0;
      hi_d     <= 1'b0;
      prod_vld <= 1'b0;
      prod_hi  <= 1'b0;
    end else begin
      // store read data is registered behind its address, so the controls are delayed to match
      mul_en_d <= ctrl.mul_en;
      hi_d     <= ctrl.hi_half;
      prod_vld <= mul_en_d;
      prod_hi  <= hi_d;
    end
  end

  assign prod_wide = {{(ACC_W-PW){prod[PW-1]}}, prod};
  assign addend    = prod_hi ? (prod_wide <<< H) : prod_wide;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + addend;
    end
  end

  // drop fraction bits (floor), then clamp to the signed data range
  assign acc_sh = acc >>> FRAC_BITS;
  assign upper  = acc_sh[ACC_W-1:DATA_WIDTH-1];
  assign fits   = (upper == '0) || (upper == '1);
  assign sat    = !fits;
  assign result = fits ? acc_sh[DATA_WIDTH-1:0] : (acc[ACC_W-1] ? MIN_VAL : MAX_VAL);

endmodule

[rtl/matrix_multiply_4x4.sv]
// 4x4 fixed point matrix multiplier: element stores, sequencer and output register
//
// Each accepted request writes one left and one right element together.
// A request with start_req set then forms left * right and delivers the 16
// elements in row-major order, last marking the sixteenth. Every element is the
// exact sum of four products, floored by FRAC_BITS bits and clamped to the signed
// DATA_WIDTH range (saturated flags a clamp). One multiplier of DATA_WIDTH by
// about DATA_WIDTH/2+1 bits does all the work, two passes per product term. Each
// element goes through the multiply passes, a read and accumulate drain and the
// output load, which waits while the output is stalled. in_stall stays high from
// a start request until the sixteenth element sits in the output register; stores
// reset to zero.
module matrix_multiply_4x4 #(
  parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mm4_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mm4_pkg::ADDR_W-1:0]  elem_index,
  input  logic [DATA_WIDTH-1:0]       left_value,
  input  logic [DATA_WIDTH-1:0]       right_value,
  input  logic                        start_req,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [DATA_WIDTH-1:0]       product_value,
  output logic [mm4_pkg::ADDR_W-1:0]  out_index,
  output logic                        saturated,
  output logic                        last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_FLUSH,
    S_DRAIN,
    S_EMIT
  } state_t;

  localparam logic [mm4_pkg::ADDR_W-1:0] LAST_ELEM = mm4_pkg::ADDR_W'(mm4_pkg::ELEMS - 1);
  localparam logic [mm4_pkg::STEP_W-1:0] LAST_STEP = mm4_pkg::STEP_W'(mm4_pkg::STEPS - 1);

  state_t                       state;
  logic [mm4_pkg::ADDR_W-1:0]   elem;
  logic [mm4_pkg::STEP_W-1:0]   step;
  logic                         in_take;
  logic                         out_free;
  logic                         out_load;
  logic [mm4_pkg::DIM_W-1:0]    term;
  logic [mm4_pkg::ADDR_W-1:0]   left_addr;
  logic [mm4_pkg::ADDR_W-1:0]   right_addr;
  logic [DATA_WIDTH-1:0]        left_rd;
  logic [DATA_WIDTH-1:0]        right_rd;
  logic [DATA_WIDTH-1:0]        mac_result;
  logic                         mac_sat;
  mm4_pkg::mac_ctrl_t           ctrl;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_EMIT) && out_free;

  // step = {term, half}; left walks the row, right walks the column
  assign term       = step[mm4_pkg::STEP_W-1:1];
  assign left_addr  = {elem[mm4_pkg::ADDR_W-1:mm4_pkg::DIM_W], term};
  assign right_addr = {term, elem[mm4_pkg::DIM_W-1:0]};

  assign ctrl.clear   = (in_take && start_req) || (state == S_EMIT && out_free);
  assign ctrl.mul_en  = (state == S_MUL);
  assign ctrl.hi_half = step[0];

  mm4_store #(.DATA_WIDTH(DATA_WIDTH)) u_left (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_take),
    .wr_addr (elem_index),
    .wr_data (left_value),
    .rd_addr (left_addr),
    .rd_data (left_rd)
  );

  mm4_store #(.DATA_WIDTH(DATA_WIDTH)) u_right (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_take),
    .wr_addr (elem_index),
    .wr_data (right_value),
    .rd_addr (right_addr),
    .rd_data (right_rd)
  );

  mm4_mac #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .left_op  (left_rd),
    .right_op (right_rd),
    .result   (mac_result),
    .sat      (mac_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      elem      <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take && start_req) begin
            state <= S_MUL;
            elem  <= '0;
            step  <= '0;
          end
        end
        S_MUL: begin
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= S_FLUSH;
          end
        end
        // last product still passes the store read and the multiplier
        S_FLUSH: begin
          state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            product_value <= mac_result;
            saturated     <= mac_sat;
            out_index     <= elem;
            last          <= (elem == LAST_ELEM);
            step          <= '0;
            if (elem == LAST_ELEM) begin
              state <= S_IDLE;
            end else begin
              elem  <= elem + 1'b1;
              state <= S_MUL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/mm4_checker.sv]
// port-level checks for the matrix multiplier, bound to the top level
module mm4_checker #(
  parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        start_req,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [DATA_WIDTH-1:0]       product_value,
  input logic [mm4_pkg::ADDR_W-1:0]  out_index,
  input logic                        saturated,
  input logic                        last
);

  localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [mm4_pkg::ADDR_W-1:0] LAST_ELEM = mm4_pkg::ADDR_W'(mm4_pkg::ELEMS - 1);

  // a start request makes the block busy on the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && start_req |=> in_stall)
    else $error("block not busy after start request");

  // last marks exactly the final element of a product
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (out_index == LAST_ELEM)))
    else $error("last flag does not match element index");

  // a clamped element sits at one of the range limits
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (product_value == MAX_VAL || product_value == MIN_VAL))
    else $error("saturated element not at a range limit");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(product_value) && $stable(out_index))
    else $error("stalled result changed");

endmodule

bind matrix_multiply_4x4 mm4_checker #(.DATA_WIDTH(DATA_WIDTH)) u_mm4_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .start_req     (start_req),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .product_value (product_value),
  .out_index     (out_index),
  .saturated     (saturated),
  .last          (last)
);
